[rtl/hfec_pkg.sv]
package hfec_pkg;

    localparam int PROG_W  = 16;
    localparam int ADDR_W  = 31;
    localparam int COUNT_W = 32;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = 1'd1;

    localparam logic [COUNT_W-1:0] HOT_THRESHOLD_RESET = 32'd1000;

    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_DISABLED = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        CMD_RECORD,
        CMD_QUERY,
        CMD_DISABLED
    } cmd_kind_t;

    typedef struct packed {
        logic [PROG_W-1:0] prog;
        logic [ADDR_W-1:0] addr;
    } key_t;

    typedef struct packed {
        cmd_kind_t kind;
        key_t      key;
    } cmd_t;

endpackage

[rtl/hfec_front.sv]
module hfec_front
    import hfec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enabled,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            q_full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    logic accept;

    assign push     = hold_valid_reg && !q_full;
    assign s_tready = !hold_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push_cmd = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (push)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next       = 1'b1;
            hold_cmd_next.key.prog = s_tdata[PROG_W:1];
            hold_cmd_next.key.addr = s_tdata[PROG_W+ADDR_W:PROG_W+1];
            if (s_tdata[0] == ACT_QUERY)
            begin
                hold_cmd_next.kind = CMD_QUERY;
            end
            else if (enabled)
            begin
                hold_cmd_next.kind = CMD_RECORD;
            end
            else
            begin
                hold_cmd_next.kind = CMD_DISABLED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

[rtl/hfec_queue.sv]
module hfec_queue
    import hfec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full    = fill_reg == 2'd2;
    assign valid   = fill_reg != 2'd0;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/hfec_back.sv]
module hfec_back
    import hfec_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] hot_threshold,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] TABLE_SIZE = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_DONE
    } state_t;

    state_t             state_reg,      state_next;
    cmd_t               cmd_reg,        cmd_next;
    logic [CNT_W-1:0]   issue_idx_reg,  issue_idx_next;
    logic               rd_valid_reg,   rd_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg,    cmp_idx_next;
    logic [CNT_W-1:0]   used_reg,       used_next;
    logic [COUNT_W-1:0] res_count_reg,  res_count_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic               out_valid_reg,  out_valid_next;
    logic [COUNT_W-1:0] out_count_reg,  out_count_next;
    logic               out_hot_reg,    out_hot_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;

    key_t               key_mem [TABLE_ENTRIES];
    logic [COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];
    key_t               key_q;
    logic [COUNT_W-1:0] cnt_q;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               key_we;
    logic               cnt_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_cnt;
    logic               match;
    logic               out_free;

    assign match    = rd_valid_reg && (key_q == cmd_reg.key);
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_status_reg, out_hot_reg, out_count_reg};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_idx_next  = issue_idx_reg;
        rd_valid_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        used_next       = used_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_count_next  = out_count_reg;
        out_hot_next    = out_hot_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_idx_reg[IDX_W-1:0];
        key_we          = 1'b0;
        cnt_we          = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_cnt          = cnt_q + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next       = q_cmd;
                    issue_idx_next = '0;
                    if (q_cmd.kind == CMD_DISABLED)
                    begin
                        res_count_next  = '0;
                        res_status_next = ST_DISABLED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_HIT;
                end
                else if (issue_idx_reg < used_reg)
                begin
                    rd_en          = 1'b1;
                    rd_valid_next  = 1'b1;
                    cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = S_MISS;
                end
            end
            S_HIT:
            begin
                res_status_next = ST_FOUND;
                if (cmd_reg.kind == CMD_QUERY)
                begin
                    res_count_next = cnt_q;
                end
                else
                begin
                    cnt_we         = 1'b1;
                    res_count_next = wr_cnt;
                end
                state_next = S_DONE;
            end
            S_MISS:
            begin
                res_count_next = '0;
                if (cmd_reg.kind == CMD_QUERY)
                begin
                    res_status_next = ST_ABSENT;
                end
                else if (used_reg >= TABLE_SIZE)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    key_we          = 1'b1;
                    cnt_we          = 1'b1;
                    wr_addr         = used_reg[IDX_W-1:0];
                    wr_cnt          = COUNT_W'(1);
                    used_next       = used_reg + 1'b1;
                    res_count_next  = COUNT_W'(1);
                    res_status_next = ST_INSERTED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                    out_hot_next    = ((res_status_reg == ST_FOUND) ||
                                       (res_status_reg == ST_INSERTED)) &&
                                      (res_count_reg >= hot_threshold);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '{kind: CMD_RECORD, key: '0};
            issue_idx_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            cmp_idx_reg    <= '0;
            used_reg       <= '0;
            res_count_reg  <= '0;
            res_status_reg <= ST_FOUND;
            out_valid_reg  <= 1'b0;
            out_count_reg  <= '0;
            out_hot_reg    <= 1'b0;
            out_status_reg <= ST_FOUND;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            issue_idx_reg  <= issue_idx_next;
            rd_valid_reg   <= rd_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            used_reg       <= used_next;
            res_count_reg  <= res_count_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_count_reg  <= out_count_next;
            out_hot_reg    <= out_hot_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= cmd_reg.key;
        end
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            key_q <= key_mem[rd_addr];
            cnt_q <= cnt_mem[rd_addr];
        end
    end

endmodule

[rtl/hot_function_entry_counter.sv]
// Counts entries per function key (program id, function address) and reports
// hot functions. Input beats on the s_ channel carry a record or a query
// request; each request yields exactly one result beat on the m_ channel, in
// request order. Configuration is written through cfg_we, cfg_addr and
// cfg_wdata while the block is idle: index 0 enables recording, index 1 sets
// the hot threshold.
// A request is captured by the front stage, classified, and passed through a
// two-entry command queue to the lookup engine. The engine scans the used
// table entries one per cycle through the key memory read port. A hit stops
// the scan at the matching key and a miss reads every used entry; a disabled
// record skips the scan. Requests are processed one at a time in the engine;
// up to three further requests are held by the front stage and the queue.
// Reset clears the table fill count, the queue and all valid flags; no
// clearing pass is needed, so the block accepts beats right after reset.
// When the receiver stalls, the result holds in the output register, the
// engine waits with the next result, and the input side keeps filling the
// queue and the front stage until both are full, then drops s_tready.
module hot_function_entry_counter
    import hfec_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: action, program_id, function_address.
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: count, hot, status, then zero padding.
    output logic [OUT_W-1:0]     m_tdata
);

    logic               enabled_reg;
    logic               enabled_next;
    logic [COUNT_W-1:0] threshold_reg;
    logic [COUNT_W-1:0] threshold_next;
    logic               q_full;
    logic               push;
    cmd_t               push_cmd;
    logic               pop;
    logic               q_valid;
    cmd_t               q_cmd;

    always_comb
    begin
        enabled_next   = enabled_reg;
        threshold_next = threshold_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENABLED:       enabled_next   = cfg_wdata[0];
                REG_HOT_THRESHOLD: threshold_next = cfg_wdata[COUNT_W-1:0];
                default:           enabled_next   = enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            threshold_reg <= HOT_THRESHOLD_RESET;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            threshold_reg <= threshold_next;
        end
    end

    hfec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enabled  (enabled_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    hfec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_cmd  (q_cmd)
    );

    hfec_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .hot_threshold (threshold_reg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

[rtl/hfec_checker.sv]
module hfec_checker
    import hfec_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               hot;

    assign status = m_tdata[COUNT_W+STAT_W:COUNT_W+1];
    assign count  = m_tdata[COUNT_W-1:0];
    assign hot    = m_tdata[COUNT_W];

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result beat shown during reset");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == ST_FOUND) || (status == ST_INSERTED) ||
                     (status == ST_FULL) || (status == ST_DISABLED) ||
                     (status == ST_ABSENT))
        else $error("unknown status code");

    a_no_count_without_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((status == ST_FULL) || (status == ST_DISABLED) ||
                     (status == ST_ABSENT)) |-> (count == '0) && !hot)
        else $error("count or hot set without a table entry");

    a_insert_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_INSERTED) |-> count == COUNT_W'(1))
        else $error("new entry does not report a count of one");

endmodule

bind hot_function_entry_counter hfec_checker u_hfec_checker (.*);

[tb/sv/hot_function_entry_counter_tb.sv]
module hot_function_entry_counter_tb;
    import hfec_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               hot;
        logic [STAT_W-1:0]  status;
    } entry_result_t;

    // Mirrors the key table and the two registers, and holds the result beats
    // that are still owed by the block, oldest first.
    class entry_tally;
        logic               enabled;
        logic [COUNT_W-1:0] threshold;
        key_t               keys[$];
        logic [COUNT_W-1:0] counts[$];
        entry_result_t      owed[$];
        int                 errors;

        function new();
            enabled   = 1'b0;
            threshold = HOT_THRESHOLD_RESET;
            errors    = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
            if (idx == REG_ENABLED)
                enabled = value[0];
            else if (idx == REG_HOT_THRESHOLD)
                threshold = value[COUNT_W-1:0];
        endfunction

        function int find_key(input key_t k);
            foreach (keys[i])
            begin
                if (keys[i] == k)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(input logic act, input key_t k);
            entry_result_t r;
            int idx;
            r.count = '0;
            r.hot   = 1'b0;
            idx     = find_key(k);
            if (act == ACT_QUERY)
            begin
                if (idx >= 0)
                begin
                    r.count  = counts[idx];
                    r.hot    = (r.count >= threshold);
                    r.status = ST_FOUND;
                end
                else
                    r.status = ST_ABSENT;
            end
            else if (!enabled)
                r.status = ST_DISABLED;
            else if (idx < 0 && keys.size() >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                if (idx < 0)
                begin
                    keys.push_back(k);
                    counts.push_back('0);
                    idx      = keys.size() - 1;
                    r.status = ST_INSERTED;
                end
                else
                    r.status = ST_FOUND;
                counts[idx] = counts[idx] + 1'b1;
                r.count     = counts[idx];
                r.hot       = (r.count >= threshold);
            end
            owed.push_back(r);
        endfunction

        function void check_result(input logic [OUT_W-1:0] data);
            entry_result_t      want;
            logic [COUNT_W-1:0] got_count;
            logic               got_hot;
            logic [STAT_W-1:0]  got_status;
            got_count  = data[COUNT_W-1:0];
            got_hot    = data[COUNT_W];
            got_status = data[COUNT_W+1 +: STAT_W];
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
                return;
            end
            want = owed.pop_front();
            if (got_count !== want.count)
            begin
                errors++;
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, want.count, got_count);
            end
            if (got_hot !== want.hot)
            begin
                errors++;
                $display("%0t: hot mismatch, expected %b, actual %b", $time, want.hot, got_hot);
            end
            if (got_status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got_status);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    bit         idling = 1'b1;
    entry_tally board  = new();

    hot_function_entry_counter #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        board.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(input logic act, input logic [PROG_W-1:0] prog,
                                input logic [ADDR_W-1:0] addr);
        key_t k;
        k.prog = prog;
        k.addr = addr;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, prog, act};
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_request(act, k);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int items, input int fresh_pct, input int query_pct);
        key_t k;
        key_t near;
        logic act;
        repeat (items)
        begin
            act = ($urandom_range(0, 99) < query_pct) ? ACT_QUERY : ACT_RECORD;
            if (board.keys.size() == 0 || $urandom_range(0, 99) < fresh_pct)
            begin
                k.prog = PROG_W'($urandom);
                k.addr = ADDR_W'($urandom);
                // A fresh key that shares one half with a stored key must still miss.
                if (board.keys.size() != 0 && $urandom_range(0, 3) == 0)
                begin
                    near = board.keys[$urandom_range(0, board.keys.size() - 1)];
                    if ($urandom_range(0, 1) == 0)
                        k.prog = near.prog;
                    else
                        k.addr = near.addr;
                end
            end
            else
                k = board.keys[$urandom_range(0, board.keys.size() - 1)];
            send_request(act, k.prog, k.addr);
        end
        settle();
    endtask

    initial
    begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                board.check_result(m_tdata);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idling && $urandom_range(0, 7) == 0)
                    stall = $urandom_range(1, 5);
            end
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset recording is off, while queries still answer.
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        send_request(ACT_QUERY, 16'h0000, 31'h0000_0000);
        send_request(ACT_RECORD, 16'hFFFF, 31'h7FFF_FFFF);
        settle();
        // Only bit 0 of the enable register is kept, so this leaves recording off.
        write_reg(REG_ENABLED, 32'hFFFF_FFFE);
        send_request(ACT_RECORD, 16'h0001, 31'h0000_0001);
        settle();

        write_reg(REG_ENABLED, 32'd1);
        write_reg(REG_HOT_THRESHOLD, 32'd0);
        send_request(ACT_QUERY, 16'h0000, 31'h0000_0000);
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        send_request(ACT_RECORD, 16'hFFFF, 31'h7FFF_FFFF);
        send_request(ACT_QUERY, 16'hFFFF, 31'h7FFF_FFFF);
        send_request(ACT_QUERY, 16'hFFFF, 31'h0000_0000);
        send_request(ACT_RECORD, 16'h0000, 31'h7FFF_FFFF);
        send_request(ACT_RECORD, 16'hFFFF, 31'h0000_0000);
        settle();

        write_reg(REG_HOT_THRESHOLD, 32'd3);
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        send_request(ACT_QUERY, 16'h0000, 31'h7FFF_FFFF);
        send_request(ACT_RECORD, 16'h0000, 31'h7FFF_FFFF);
        settle();

        write_reg(REG_HOT_THRESHOLD, 32'hFFFF_FFFF);
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        send_request(ACT_QUERY, 16'h0000, 31'h0000_0000);
        settle();

        write_reg(REG_ENABLED, 32'd0);
        send_request(ACT_QUERY, 16'h0000, 31'h0000_0000);
        send_request(ACT_RECORD, 16'h0000, 31'h0000_0000);
        settle();

        write_reg(REG_ENABLED, 32'd1);
        write_reg(REG_HOT_THRESHOLD, $urandom_range(2, 8));
        run_random(600, 20, 20);

        write_reg(REG_ENABLED, 32'd0);
        write_reg(REG_HOT_THRESHOLD, $urandom);
        run_random(200, 20, 50);

        // Enough fresh keys arrive here to fill the table and then overflow it.
        write_reg(REG_ENABLED, 32'd1);
        write_reg(REG_HOT_THRESHOLD, $urandom_range(5, 15));
        run_random(900, 30, 15);

        write_reg(REG_HOT_THRESHOLD, 32'd1);
        idling = 1'b0;
        run_random(200, 20, 20);

        repeat (TABLE_DEPTH + 10) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
rtl/hfec_pkg.sv
rtl/hfec_front.sv
rtl/hfec_queue.sv
rtl/hfec_back.sv
rtl/hot_function_entry_counter.sv
rtl/hfec_checker.sv
tb/sv/hot_function_entry_counter_tb.sv
